[rtl/core/i2cseq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Phase encoding, command and control codes, and the word types shared by
// the sequencer modules.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

    typedef enum logic [11:0] {
        PH_IDLE     = 12'b0000_0000_0001,
        PH_SB_W     = 12'b0000_0000_0010,
        PH_ADDR_W   = 12'b0000_0000_0100,
        PH_WR_DATA  = 12'b0000_0000_1000,
        PH_RESTART  = 12'b0000_0001_0000,
        PH_SB_R     = 12'b0000_0010_0000,
        PH_ADDR_R   = 12'b0000_0100_0000,
        PH_RD_BULK  = 12'b0000_1000_0000,
        PH_RD_LAST3 = 12'b0001_0000_0000,
        PH_RD_FINAL = 12'b0010_0000_0000,
        PH_RD_TWO   = 12'b0100_0000_0000,
        PH_RD_ONE   = 12'b1000_0000_0000
    } phase_t;

    localparam logic [1:0] OP_START_WR = 2'd0;
    localparam logic [1:0] OP_START_RD = 2'd1;
    localparam logic [1:0] OP_EVENT    = 2'd2;

    localparam logic [1:0] CTL_NONE = 2'd0;
    localparam logic [1:0] CTL_ON   = 2'd1;
    localparam logic [1:0] CTL_OFF  = 2'd2;

    localparam int EV_SB   = 0;
    localparam int EV_ADDR = 1;
    localparam int EV_RXNE = 2;
    localparam int EV_BTF  = 3;
    localparam int EV_TXE  = 4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] slave_addr;
        logic [7:0] target_register;
        logic [7:0] transfer_length;
        logic [7:0] tx_byte;
        logic [4:0] event_flags;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
    } cmd_t;

    typedef struct packed {
        logic       dr_write_valid;
        logic [7:0] dr_write_value;
        logic       start_request;
        logic       stop_request;
        logic [1:0] ack_control;
        logic [1:0] pos_set;
        logic [1:0] buffer_irq_control;
        logic [1:0] store_count;
        logic [7:0] store_first;
        logic [7:0] store_second;
        logic       tx_consumed;
        logic       idle;
    } rsp_t;

endpackage

[rtl/core/i2c_master_register_transfer_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register transfer sequencer
// Steps an I2C master register read or write through start commands and
// peripheral events, one result word per command word.
// ----------------------------------------------------------------------------
// Each command word accepted on the cmd channel yields exactly one result word
// on the rsp channel, in order. The block takes one word per clock cycle while
// rsp_ready holds no result back; a command passes the input register, and
// the combinational sequencer step turns it into a result word that it loads
// into the output register once that register is free.
// Back-pressure on rsp_ready holds the output register, and the input
// register then fills and drops cmd_ready until space frees up.
module i2c_master_register_transfer_sequencer import i2cseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [1:0] opcode,
    input  logic [6:0] slave_addr,
    input  logic [7:0] target_register,
    input  logic [7:0] transfer_length,
    input  logic [7:0] tx_byte,
    input  logic [4:0] event_flags,
    input  logic [7:0] rx_first,
    input  logic [7:0] rx_second,

    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic       dr_write_valid,
    output logic [7:0] dr_write_value,
    output logic       start_request,
    output logic       stop_request,
    output logic [1:0] ack_control,
    output logic [1:0] pos_set,
    output logic [1:0] buffer_irq_control,
    output logic [1:0] store_count,
    output logic [7:0] store_first,
    output logic [7:0] store_second,
    output logic       tx_consumed,
    output logic       idle
);

    cmd_t cmd_word;
    cmd_t held_cmd;
    logic held_valid;
    logic out_free;
    logic advance;
    rsp_t step_rsp;
    rsp_t out_rsp;

    assign cmd_word.opcode          = opcode;
    assign cmd_word.slave_addr      = slave_addr;
    assign cmd_word.target_register = target_register;
    assign cmd_word.transfer_length = transfer_length;
    assign cmd_word.tx_byte         = tx_byte;
    assign cmd_word.event_flags     = event_flags;
    assign cmd_word.rx_first        = rx_first;
    assign cmd_word.rx_second       = rx_second;

    assign advance = held_valid && out_free;

    i2cseq_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd_word),
        .advance    (advance),
        .held_valid (held_valid),
        .held_cmd   (held_cmd)
    );

    i2cseq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (held_cmd),
        .rsp     (step_rsp)
    );

    i2cseq_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .rsp_in    (step_rsp),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_out   (out_rsp)
    );

    assign dr_write_valid     = out_rsp.dr_write_valid;
    assign dr_write_value     = out_rsp.dr_write_value;
    assign start_request      = out_rsp.start_request;
    assign stop_request       = out_rsp.stop_request;
    assign ack_control        = out_rsp.ack_control;
    assign pos_set            = out_rsp.pos_set;
    assign buffer_irq_control = out_rsp.buffer_irq_control;
    assign store_count        = out_rsp.store_count;
    assign store_first        = out_rsp.store_first;
    assign store_second       = out_rsp.store_second;
    assign tx_consumed        = out_rsp.tx_consumed;
    assign idle               = out_rsp.idle;

endmodule

[rtl/core/i2cseq_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command input register
// Holds one accepted command word until the sequencer core takes it.
// ----------------------------------------------------------------------------
module i2cseq_in_reg import i2cseq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    input  logic advance,
    output logic held_valid,
    output cmd_t held_cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;

    assign cmd_ready  = !valid_reg || advance;
    assign valid_next = (cmd_valid && cmd_ready) || (valid_reg && !advance);
    assign held_valid = valid_reg;
    assign held_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
    end

endmodule

[rtl/core/i2cseq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer core
// Transfer state and the combinational step that turns one command word into
// one result word.
// ----------------------------------------------------------------------------
module i2cseq_core import i2cseq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  cmd_t cmd,
    output rsp_t rsp
);

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [6:0] slave_reg, slave_next;
    logic [7:0] register_reg, register_next;
    logic       read_dir_reg, read_dir_next;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        slave_next     = slave_reg;
        register_next  = register_reg;
        read_dir_next  = read_dir_reg;
        rsp            = '0;

        if (cmd.opcode == OP_START_WR || cmd.opcode == OP_START_RD)
        begin
            if (phase_reg == PH_IDLE &&
                !(cmd.opcode == OP_START_RD && cmd.transfer_length == 8'd0))
            begin
                slave_next        = cmd.slave_addr;
                register_next     = cmd.target_register;
                remaining_next    = cmd.transfer_length;
                read_dir_next     = cmd.opcode[0];
                rsp.start_request = 1'b1;
                if (cmd.opcode == OP_START_RD)
                begin
                    rsp.ack_control = CTL_ON;
                    rsp.pos_set     = CTL_OFF;
                end
                phase_next = PH_SB_W;
            end
        end
        else if (cmd.opcode == OP_EVENT)
        begin
            // Handlers run in a fixed order; each sees the phase left by the one before.
            if (cmd.event_flags[EV_SB])
            begin
                if (phase_next == PH_SB_W)
                begin
                    rsp.dr_write_valid = 1'b1;
                    rsp.dr_write_value = {slave_reg, 1'b0};
                    phase_next         = PH_ADDR_W;
                end
                else if (phase_next == PH_SB_R)
                begin
                    rsp.dr_write_valid = 1'b1;
                    rsp.dr_write_value = {slave_reg, 1'b1};
                    phase_next         = PH_ADDR_R;
                end
            end

            if (cmd.event_flags[EV_ADDR])
            begin
                if (phase_next == PH_ADDR_R)
                begin
                    if (remaining_next == 8'd1)
                    begin
                        rsp.ack_control        = CTL_OFF;
                        rsp.stop_request       = 1'b1;
                        rsp.buffer_irq_control = CTL_ON;
                        phase_next             = PH_RD_ONE;
                    end
                    else if (remaining_next == 8'd2)
                    begin
                        rsp.pos_set     = CTL_ON;
                        rsp.ack_control = CTL_OFF;
                        phase_next      = PH_RD_TWO;
                    end
                    else if (remaining_next == 8'd3)
                    begin
                        phase_next = PH_RD_LAST3;
                    end
                    else
                    begin
                        phase_next = PH_RD_BULK;
                    end
                end
                else if (phase_next == PH_ADDR_W)
                begin
                    rsp.dr_write_valid = 1'b1;
                    rsp.dr_write_value = register_reg;
                    phase_next         = read_dir_reg ? PH_RESTART : PH_WR_DATA;
                end
            end

            if (cmd.event_flags[EV_RXNE])
            begin
                if (phase_next == PH_RD_ONE || phase_next == PH_RD_FINAL)
                begin
                    rsp.store_count  = 2'd1;
                    rsp.store_first  = cmd.rx_first;
                    rsp.store_second = 8'd0;
                    phase_next       = PH_IDLE;
                end
                rsp.buffer_irq_control = CTL_OFF;
            end

            if (cmd.event_flags[EV_BTF])
            begin
                case (phase_next)
                    PH_RD_TWO:
                    begin
                        rsp.stop_request = 1'b1;
                        rsp.store_count  = 2'd2;
                        rsp.store_first  = cmd.rx_first;
                        rsp.store_second = cmd.rx_second;
                        phase_next       = PH_IDLE;
                    end
                    PH_RD_BULK:
                    begin
                        rsp.store_count  = 2'd1;
                        rsp.store_first  = cmd.rx_first;
                        rsp.store_second = 8'd0;
                        remaining_next   = remaining_next - 8'd1;
                        if (remaining_next <= 8'd3)
                        begin
                            phase_next = PH_RD_LAST3;
                        end
                    end
                    PH_RD_LAST3:
                    begin
                        rsp.ack_control        = CTL_OFF;
                        rsp.store_count        = 2'd2;
                        rsp.store_first        = cmd.rx_first;
                        rsp.store_second       = cmd.rx_second;
                        rsp.stop_request       = 1'b1;
                        rsp.buffer_irq_control = CTL_ON;
                        phase_next             = PH_RD_FINAL;
                    end
                    PH_WR_DATA:
                    begin
                        if (remaining_next != 8'd0 && cmd.event_flags[EV_TXE])
                        begin
                            rsp.dr_write_valid = 1'b1;
                            rsp.dr_write_value = cmd.tx_byte;
                            rsp.tx_consumed    = 1'b1;
                            remaining_next     = remaining_next - 8'd1;
                        end
                        else
                        begin
                            rsp.stop_request = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                    end
                    PH_RESTART:
                    begin
                        rsp.start_request = 1'b1;
                        phase_next        = PH_SB_R;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        rsp.idle = (phase_next == PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 8'd0;
            slave_reg     <= 7'd0;
            register_reg  <= 8'd0;
            read_dir_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            slave_reg     <= slave_next;
            register_reg  <= register_next;
            read_dir_reg  <= read_dir_next;
        end
    end

endmodule

[rtl/core/i2cseq_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module i2cseq_out_reg import i2cseq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  rsp_t rsp_in,
    output logic free,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_out
);

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign free       = !valid_reg || rsp_ready;
    assign valid_next = load || (valid_reg && !rsp_ready);
    assign rsp_valid  = valid_reg;
    assign rsp_out    = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_in;
        end
    end

endmodule

[rtl/core/i2cseq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cseq_checker import i2cseq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       dr_write_valid,
    input logic [7:0] dr_write_value,
    input logic       start_request,
    input logic       stop_request,
    input logic [1:0] store_count,
    input logic [7:0] store_first,
    input logic [7:0] store_second,
    input logic       tx_consumed,
    input logic       idle
);

    // A stalled result word must hold.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(dr_write_value)
            && $stable(store_first) && $stable(store_second) && $stable(idle))
        else $error("result word changed while stalled");

    // Unused payload bytes read as zero.
    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (dr_write_valid || dr_write_value == 8'd0)
            && (store_count == 2'd2 || store_second == 8'd0)
            && (store_count != 2'd0 || store_first == 8'd0))
        else $error("unused result byte not zero");

    // A sent data byte keeps the transfer going.
    a_tx_sent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && tx_consumed |-> dr_write_valid && !idle && !stop_request)
        else $error("tx byte consumed without a data write");

    // A start request never comes with a stop and always leaves the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && start_request |-> !stop_request && !idle && store_count == 2'd0)
        else $error("start request with stop, store or idle");

endmodule

bind i2c_master_register_transfer_sequencer i2cseq_checker u_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the I2C master register transfer sequencer
// Drives start commands and peripheral events through the cmd channel and
// checks every result word against a cycle-free model of the sequencer or a
// fixed word from the table. A short directed table comes first, then random
// transfers that mostly follow the event order the sequencer expects, with some noise mixed in.
// ----------------------------------------------------------------------------
module tb import i2cseq_pkg::*;
;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [4:0] F_SB   = 5'(1 << EV_SB);
    localparam logic [4:0] F_ADDR = 5'(1 << EV_ADDR);
    localparam logic [4:0] F_RXNE = 5'(1 << EV_RXNE);
    localparam logic [4:0] F_BTF  = 5'(1 << EV_BTF);
    localparam logic [4:0] F_TXE  = 5'(1 << EV_TXE);

    localparam int TOTAL_WORDS = 1450;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    logic [1:0] opcode = '0;
    logic [6:0] slave_addr = '0;
    logic [7:0] target_register = '0;
    logic [7:0] transfer_length = '0;
    logic [7:0] tx_byte = '0;
    logic [4:0] event_flags = '0;
    logic [7:0] rx_first = '0;
    logic [7:0] rx_second = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic       dr_write_valid;
    logic [7:0] dr_write_value;
    logic       start_request;
    logic       stop_request;
    logic [1:0] ack_control;
    logic [1:0] pos_set;
    logic [1:0] buffer_irq_control;
    logic [1:0] store_count;
    logic [7:0] store_first;
    logic [7:0] store_second;
    logic       tx_consumed;
    logic       idle;

    // Model state of the sequencer.
    phase_t     seq_phase = PH_IDLE;
    logic [7:0] seq_left = '0;
    logic [6:0] seq_slave = '0;
    logic [7:0] seq_reg = '0;
    logic       seq_read = 1'b0;

    rsp_t pending_results[$];
    cmd_t table_cmd[$];
    bit   table_typed[$];
    rsp_t table_result[$];

    bit calm = 1'b0;
    int n_errors = 0;
    int n_results = 0;
    int n_sent = 0;
    int n_noise = 0;
    int n_writes = 0;
    int n_reads = 0;
    int longest_read = 0;

    always #4 clk = ~clk;

    i2c_master_register_transfer_sequencer u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd_valid          (cmd_valid),
        .cmd_ready          (cmd_ready),
        .opcode             (opcode),
        .slave_addr         (slave_addr),
        .target_register    (target_register),
        .transfer_length    (transfer_length),
        .tx_byte            (tx_byte),
        .event_flags        (event_flags),
        .rx_first           (rx_first),
        .rx_second          (rx_second),
        .rsp_valid          (rsp_valid),
        .rsp_ready          (rsp_ready),
        .dr_write_valid     (dr_write_valid),
        .dr_write_value     (dr_write_value),
        .start_request      (start_request),
        .stop_request       (stop_request),
        .ack_control        (ack_control),
        .pos_set            (pos_set),
        .buffer_irq_control (buffer_irq_control),
        .store_count        (store_count),
        .store_first        (store_first),
        .store_second       (store_second),
        .tx_consumed        (tx_consumed),
        .idle               (idle)
    );

    // Advances the model by one command word and returns the result word.
    function automatic rsp_t sequencer_step(input cmd_t c);
        rsp_t r;
        r = '0;
        if (c.opcode == OP_START_WR || c.opcode == OP_START_RD)
        begin
            if (seq_phase == PH_IDLE &&
                !(c.opcode == OP_START_RD && c.transfer_length == 8'd0))
            begin
                seq_slave = c.slave_addr;
                seq_reg   = c.target_register;
                seq_left  = c.transfer_length;
                seq_read  = (c.opcode == OP_START_RD);
                r.start_request = 1'b1;
                if (seq_read)
                begin
                    r.ack_control = CTL_ON;
                    r.pos_set     = CTL_OFF;
                    n_reads++;
                    if (int'(c.transfer_length) > longest_read)
                        longest_read = int'(c.transfer_length);
                end
                else
                begin
                    n_writes++;
                end
                seq_phase = PH_SB_W;
            end
        end
        else if (c.opcode == OP_EVENT)
        begin
            if (c.event_flags[EV_SB])
            begin
                if (seq_phase == PH_SB_W)
                begin
                    r.dr_write_valid = 1'b1;
                    r.dr_write_value = {seq_slave, 1'b0};
                    seq_phase = PH_ADDR_W;
                end
                else if (seq_phase == PH_SB_R)
                begin
                    r.dr_write_valid = 1'b1;
                    r.dr_write_value = {seq_slave, 1'b1};
                    seq_phase = PH_ADDR_R;
                end
            end
            if (c.event_flags[EV_ADDR])
            begin
                if (seq_phase == PH_ADDR_R)
                begin
                    if (seq_left == 8'd1)
                    begin
                        r.ack_control        = CTL_OFF;
                        r.stop_request       = 1'b1;
                        r.buffer_irq_control = CTL_ON;
                        seq_phase = PH_RD_ONE;
                    end
                    else if (seq_left == 8'd2)
                    begin
                        r.pos_set     = CTL_ON;
                        r.ack_control = CTL_OFF;
                        seq_phase = PH_RD_TWO;
                    end
                    else if (seq_left == 8'd3)
                    begin
                        seq_phase = PH_RD_LAST3;
                    end
                    else
                    begin
                        seq_phase = PH_RD_BULK;
                    end
                end
                else if (seq_phase == PH_ADDR_W)
                begin
                    r.dr_write_valid = 1'b1;
                    r.dr_write_value = seq_reg;
                    seq_phase = seq_read ? PH_RESTART : PH_WR_DATA;
                end
            end
            if (c.event_flags[EV_RXNE])
            begin
                if (seq_phase == PH_RD_ONE || seq_phase == PH_RD_FINAL)
                begin
                    r.store_count  = 2'd1;
                    r.store_first  = c.rx_first;
                    r.store_second = '0;
                    seq_phase = PH_IDLE;
                end
                r.buffer_irq_control = CTL_OFF;
            end
            if (c.event_flags[EV_BTF])
            begin
                case (seq_phase)
                    PH_RD_TWO:
                    begin
                        r.stop_request = 1'b1;
                        r.store_count  = 2'd2;
                        r.store_first  = c.rx_first;
                        r.store_second = c.rx_second;
                        seq_phase = PH_IDLE;
                    end
                    PH_RD_BULK:
                    begin
                        r.store_count  = 2'd1;
                        r.store_first  = c.rx_first;
                        r.store_second = '0;
                        seq_left = seq_left - 8'd1;
                        if (seq_left <= 8'd3)
                            seq_phase = PH_RD_LAST3;
                    end
                    PH_RD_LAST3:
                    begin
                        r.ack_control        = CTL_OFF;
                        r.store_count        = 2'd2;
                        r.store_first        = c.rx_first;
                        r.store_second       = c.rx_second;
                        r.stop_request       = 1'b1;
                        r.buffer_irq_control = CTL_ON;
                        seq_phase = PH_RD_FINAL;
                    end
                    PH_WR_DATA:
                    begin
                        if (seq_left != 8'd0 && c.event_flags[EV_TXE])
                        begin
                            r.dr_write_valid = 1'b1;
                            r.dr_write_value = c.tx_byte;
                            r.tx_consumed    = 1'b1;
                            seq_left = seq_left - 8'd1;
                        end
                        else
                        begin
                            r.stop_request = 1'b1;
                            seq_phase = PH_IDLE;
                        end
                    end
                    PH_RESTART:
                    begin
                        r.start_request = 1'b1;
                        seq_phase = PH_SB_R;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        r.idle = (seq_phase == PH_IDLE);
        return r;
    endfunction

    function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [6:0] sa,
                                    input logic [7:0] reg_addr, input logic [7:0] len,
                                    input logic [7:0] tx, input logic [4:0] ev,
                                    input logic [7:0] r1, input logic [7:0] r2);
        cmd_t c;
        c.opcode          = op;
        c.slave_addr      = sa;
        c.target_register = reg_addr;
        c.transfer_length = len;
        c.tx_byte         = tx;
        c.event_flags     = ev;
        c.rx_first        = r1;
        c.rx_second       = r2;
        return c;
    endfunction

    // A result word that carries nothing but the start, stop, buffer
    // interrupt and idle indications.
    function automatic rsp_t plain_result(input logic start_req, input logic stop_req,
                                          input logic [1:0] birq, input logic idl);
        rsp_t r;
        r = '0;
        r.start_request      = start_req;
        r.stop_request       = stop_req;
        r.buffer_irq_control = birq;
        r.idle               = idl;
        return r;
    endfunction

    task automatic add_row(input cmd_t c, input bit typed, input rsp_t want);
        table_cmd.push_back(c);
        table_typed.push_back(typed);
        table_result.push_back(want);
    endtask

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Short transfers dominate; a few long ones reach the top of the range.
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(0, 4));
        if (r < 85)
            return 8'($urandom_range(5, 12));
        if (r < 98)
            return 8'($urandom_range(13, 40));
        return 8'($urandom_range(120, 255));
    endfunction

    // Turns a random word into the one the sequencer is waiting for in its
    // present phase, keeping the random payload of the unused fields.
    function automatic cmd_t shape_legal(input cmd_t c);
        logic [4:0] extra;
        extra = ($urandom_range(0, 3) == 0) ? F_TXE : 5'd0;
        c.opcode = OP_EVENT;
        case (seq_phase)
            PH_IDLE:
            begin
                c.opcode = ($urandom_range(0, 1) == 1) ? OP_START_RD : OP_START_WR;
                c.transfer_length = pick_length();
            end
            PH_SB_W, PH_SB_R:
                c.event_flags = F_SB | extra |
                                (($urandom_range(0, 2) == 0) ? F_ADDR : 5'd0);
            PH_ADDR_W, PH_ADDR_R:
                c.event_flags = F_ADDR | extra;
            PH_WR_DATA:
                c.event_flags = (($urandom_range(0, 29) == 0) ? F_BTF : (F_BTF | F_TXE)) |
                                (($urandom_range(0, 7) == 0) ? F_RXNE : 5'd0);
            PH_RD_ONE, PH_RD_FINAL:
                c.event_flags = F_RXNE | extra |
                                (($urandom_range(0, 7) == 0) ? F_BTF : 5'd0);
            default:
                c.event_flags = F_BTF | extra |
                                (($urandom_range(0, 7) == 0) ? F_RXNE : 5'd0);
        endcase
        return c;
    endfunction

    // Offers one word after an optional gap and waits for it to be taken.
    task automatic send_word(input cmd_t c, input bit typed, input rsp_t want);
        int   gap;
        rsp_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid       <= 1'b1;
        opcode          <= c.opcode;
        slave_addr      <= c.slave_addr;
        target_register <= c.target_register;
        transfer_length <= c.transfer_length;
        tx_byte         <= c.tx_byte;
        event_flags     <= c.event_flags;
        rx_first        <= c.rx_first;
        rx_second       <= c.rx_second;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        pred = sequencer_step(c);
        pending_results.push_back(typed ? want : pred);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("result %0d, %s: expected %0h, got %0h",
                         n_results, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result %0d arrived with nothing expected", n_results);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("dr_write_valid", dr_write_valid, want.dr_write_valid);
                check_field("dr_write_value", dr_write_value, want.dr_write_value);
                check_field("start_request", start_request, want.start_request);
                check_field("stop_request", stop_request, want.stop_request);
                check_field("ack_control", ack_control, want.ack_control);
                check_field("pos_set", pos_set, want.pos_set);
                check_field("buffer_irq_control", buffer_irq_control,
                            want.buffer_irq_control);
                check_field("store_count", store_count, want.store_count);
                check_field("store_first", store_first, want.store_first);
                check_field("store_second", store_second, want.store_second);
                check_field("tx_consumed", tx_consumed, want.tx_consumed);
                check_field("idle", idle, want.idle);
            end
            n_results++;
        end
    end

    // Receiver back-pressure, sharing the gap profile of the sender.
    initial
    begin : rsp_stall
        int n;
        @(negedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        cmd_t        c;
        logic [63:0] raw;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Events while idle, an ignored start and the unused opcode.
        add_row(mk_cmd(OP_EVENT, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 5'h1F, 8'hFF, 8'hFF),
                1'b1, plain_result(1'b0, 1'b0, CTL_OFF, 1'b1));
        add_row(mk_cmd(OP_START_RD, 7'h7F, 8'hFF, 8'h00, 8'h00, 5'h00, 8'h00, 8'h00),
                1'b1, plain_result(1'b0, 1'b0, CTL_NONE, 1'b1));
        add_row(mk_cmd(OP_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 5'h1F, 8'hFF, 8'hFF),
                1'b1, plain_result(1'b0, 1'b0, CTL_NONE, 1'b1));
        // Write of length zero, with a start arriving while busy.
        add_row(mk_cmd(OP_START_WR, 7'h7F, 8'hFF, 8'h00, 8'h00, 5'h00, 8'h00, 8'h00),
                1'b1, plain_result(1'b1, 1'b0, CTL_NONE, 1'b0));
        add_row(mk_cmd(OP_START_RD, 7'h00, 8'h00, 8'h05, 8'h00, 5'h00, 8'h00, 8'h00),
                1'b1, plain_result(1'b0, 1'b0, CTL_NONE, 1'b0));
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_SB, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_ADDR, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'hAA, F_BTF, 8'h00, 8'h00),
                1'b1, plain_result(1'b0, 1'b1, CTL_NONE, 1'b1));
        // Two-byte write; start-sent and address-acked in one event.
        add_row(mk_cmd(OP_START_WR, 7'h2A, 8'h00, 8'h02, 8'h00, 5'h00, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_SB | F_ADDR, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_BTF | F_TXE, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'hFF, F_BTF | F_TXE | F_RXNE,
                       8'h00, 8'h00), 1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h5A, F_BTF | F_TXE, 8'h00, 8'h00),
                1'b0, '0);
        // One-byte read.
        add_row(mk_cmd(OP_START_RD, 7'h00, 8'h00, 8'h01, 8'h00, 5'h00, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_SB, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_ADDR, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_BTF, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_SB | F_ADDR, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_RXNE, 8'hFF, 8'h00),
                1'b0, '0);
        // Two-byte read.
        add_row(mk_cmd(OP_START_RD, 7'h7F, 8'h80, 8'h02, 8'h00, 5'h00, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_SB | F_ADDR, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_BTF | F_TXE, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_SB, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_ADDR | F_TXE, 8'h00, 8'h00),
                1'b0, '0);
        add_row(mk_cmd(OP_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, F_BTF, 8'h00, 8'hFF),
                1'b0, '0);

        @(negedge clk);
        foreach (table_cmd[i])
            send_word(table_cmd[i], table_typed[i], table_result[i]);

        while (n_sent < TOTAL_WORDS)
        begin
            if (n_sent % 120 == 0)
                calm = ($urandom_range(0, 2) == 0);
            raw = {$urandom(), $urandom()};
            c = raw[$bits(cmd_t)-1:0];
            if ($urandom_range(0, 99) < 7)
            begin
                c.opcode = 2'($urandom_range(0, 3));
                n_noise++;
            end
            else
            begin
                c = shape_legal(c);
            end
            send_word(c, 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d command words sent (%0d of them noise), %0d results checked",
                 n_sent, n_noise, n_results);
        $display("%0d write and %0d read transfers started, longest read %0d bytes",
                 n_writes, n_reads, longest_read);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("timeout with %0d results still expected", pending_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule
